>>> sv/float_debounce_pump_interlock_core_macros.svh
// Assertion macros for the float pump interlock core.
`ifndef FLOAT_DEBOUNCE_PUMP_INTERLOCK_CORE_MACROS_SVH
`define FLOAT_DEBOUNCE_PUMP_INTERLOCK_CORE_MACROS_SVH

`ifndef SYNTH
`define FDPI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fdpi assertion failed");
`define FDPI_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("fdpi assertion failed");
`else
`define FDPI_ASSERT(lbl, prop)
`define FDPI_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> sv/fdpi_pkg.sv
`timescale 1ns / 1ps

package fdpi_pkg;

  localparam int unsigned WinW   = 16;
  localparam int unsigned TimerW = 32;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CfgW   = 32;

  localparam logic [WinW-1:0]   FloatWinRst = 16'd50;
  localparam logic [WinW-1:0]   GallonWinRst = 16'd500;
  localparam logic [TimerW-1:0] MaxRunRst = 32'd300000;
  localparam logic [TimerW-1:0] MinRestRst = 32'd10000;

  localparam logic [IdxW-1:0] RegFloatWin  = 8'd0;
  localparam logic [IdxW-1:0] RegGallonWin = 8'd1;
  localparam logic [IdxW-1:0] RegMaxRun    = 8'd2;
  localparam logic [IdxW-1:0] RegMinRest   = 8'd3;

  localparam logic [1:0] LevelLow  = 2'd0;
  localparam logic [1:0] LevelMid  = 2'd1;
  localparam logic [1:0] LevelHigh = 2'd2;

  typedef struct packed {
    logic gallon;
    logic high;
    logic mid;
  } fdpi_levels_t;

  typedef struct packed {
    logic drive;
    logic overrun;
    logic fresh;
  } fdpi_pump_t;

endpackage

>>> sv/fdpi_debounce.sv
`timescale 1ns / 1ps
`include "float_debounce_pump_interlock_core_macros.svh"

module fdpi_debounce (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    prime_i,
  input  logic                    raw_i,
  input  logic [fdpi_pkg::WinW-1:0] window_i,
  output logic                    level_o
);

  logic                      level_q, level_d;
  logic                      cand_q, cand_d;
  logic [fdpi_pkg::WinW-1:0] cnt_q, cnt_d, cnt_inc;

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    level_d = level_q;
    cand_d  = cand_q;
    cnt_d   = cnt_q;
    if (prime_i) begin
      level_d = raw_i;
      cand_d  = raw_i;
      cnt_d   = '0;
    end else if (raw_i != cand_q) begin
      cand_d = raw_i;
      cnt_d  = '0;
    end else begin
      cnt_d = cnt_inc;
      if (raw_i != level_q && cnt_inc >= window_i) begin
        level_d = raw_i;
      end
    end
  end

  assign level_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      cand_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (en_i) begin
      level_q <= level_d;
      cand_q  <= cand_d;
      cnt_q   <= cnt_d;
    end
  end

  `FDPI_ASSERT_NEXT(a_cnt_clear, en_i && !prime_i && raw_i != cand_q, cnt_q == '0)

endmodule

>>> sv/fdpi_pump.sv
`timescale 1ns / 1ps
`include "float_debounce_pump_interlock_core_macros.svh"

module fdpi_pump (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  fdpi_pkg::fdpi_levels_t      levels_i,
  input  logic [fdpi_pkg::TimerW-1:0] max_run_i,
  input  logic [fdpi_pkg::TimerW-1:0] min_rest_i,
  output fdpi_pkg::fdpi_pump_t        pump_o
);

  logic                        running_q, running_d;
  logic                        overrun_q, overrun_d;
  logic [fdpi_pkg::TimerW-1:0] phase_q, phase_d, phase_inc;
  logic                        want;
  logic                        fresh;

  assign phase_inc = (phase_q == '1) ? phase_q : phase_q + 1'b1;

  always_comb begin
    priority if (levels_i.high) want = 1'b0;
    else if (levels_i.mid)      want = 1'b1;
    else                        want = running_q;
  end

  always_comb begin
    running_d = running_q;
    overrun_d = overrun_q;
    phase_d   = phase_inc;
    fresh     = 1'b0;
    priority if (levels_i.gallon) begin
      if (running_q) begin
        running_d = 1'b0;
        phase_d   = '0;
      end
    end else if (want && running_q && phase_inc >= max_run_i) begin
      running_d = 1'b0;
      phase_d   = '0;
      overrun_d = 1'b1;
      fresh     = !overrun_q;
    end else if (want && !running_q && phase_inc < min_rest_i) begin
      running_d = running_q;
    end else if (want != running_q) begin
      running_d = want;
      phase_d   = '0;
    end
  end

  assign pump_o.drive   = running_d;
  assign pump_o.overrun = overrun_d;
  assign pump_o.fresh   = fresh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      overrun_q <= 1'b0;
      phase_q   <= '0;
    end else if (en_i) begin
      running_q <= running_d;
      overrun_q <= overrun_d;
      phase_q   <= phase_d;
    end
  end

  `FDPI_ASSERT_NEXT(a_overrun_sticky, overrun_q, overrun_q)
  `FDPI_ASSERT(a_start_rested, en_i && !running_q && running_d |-> phase_inc >= min_rest_i)

endmodule

>>> sv/float_debounce_pump_interlock_core.sv
`timescale 1ns / 1ps
`include "float_debounce_pump_interlock_core_macros.svh"
// Float switch pump controller with dry-run interlock.
// s_axis carries one 1 ms tick per beat with the three active-low float pins;
// m_axis returns one status beat per tick: pump command, overrun fault and the
// debounced float conditions with a tank level code.
// The cfg channel writes the four timing registers (index 0..3, others are
// dropped); cfg_ready_o is always high. Write only while the core is idle.
// A tick beat is taken into the input register, then its status beat into the
// status register. Throughput: one beat per cycle while m_axis does not stall;
// the input register and the status register form a two-stage chain, and all
// debounce and pump rules settle in the single combinational step between them.
// Reset clears all float, pump and fault state and loads the register
// defaults; the first tick after reset primes the debounced levels directly
// from the pins.
// When m_axis stalls the status beat is held and the input register still
// takes one more beat; s_axis_tready then drops until the status beat drains.

module float_debounce_pump_interlock_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [0] mid_pin_level, [1] high_pin_level, [2] gallon_pin_level, [7:3] zero
  input  logic [7:0]                  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] pump_drive, [1] overrun_latched, [2] overrun_new, [3] below_mid,
  // [4] at_high, [5] gallon_empty, [7:6] tank_level
  output logic [7:0]                  m_axis_tdata,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fdpi_pkg::IdxW-1:0]   cfg_index_i,
  input  logic [fdpi_pkg::CfgW-1:0]   cfg_data_i
);

  logic                        in_valid_q, in_valid_d;
  logic [2:0]                  pins_q;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_data_q;
  logic                        primed_q;
  logic                        adv;
  logic                        s_acc;
  logic [fdpi_pkg::WinW-1:0]   float_win_q;
  logic [fdpi_pkg::WinW-1:0]   gallon_win_q;
  logic [fdpi_pkg::TimerW-1:0] max_run_q;
  logic [fdpi_pkg::TimerW-1:0] min_rest_q;
  fdpi_pkg::fdpi_levels_t      raw;
  fdpi_pkg::fdpi_levels_t      levels;
  fdpi_pkg::fdpi_pump_t        pump;
  logic [1:0]                  tank_level;
  logic [7:0]                  result;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign in_valid_d  = s_acc ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign out_valid_d = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  assign raw.mid    = ~pins_q[0];
  assign raw.high   = ~pins_q[1];
  assign raw.gallon = ~pins_q[2];

  fdpi_debounce u_mid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .prime_i  (!primed_q),
    .raw_i    (raw.mid),
    .window_i (float_win_q),
    .level_o  (levels.mid)
  );

  fdpi_debounce u_high (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .prime_i  (!primed_q),
    .raw_i    (raw.high),
    .window_i (float_win_q),
    .level_o  (levels.high)
  );

  fdpi_debounce u_gallon (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .prime_i  (!primed_q),
    .raw_i    (raw.gallon),
    .window_i (gallon_win_q),
    .level_o  (levels.gallon)
  );

  fdpi_pump u_pump (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .levels_i   (levels),
    .max_run_i  (max_run_q),
    .min_rest_i (min_rest_q),
    .pump_o     (pump)
  );

  always_comb begin
    priority if (levels.high) tank_level = fdpi_pkg::LevelHigh;
    else if (levels.mid)      tank_level = fdpi_pkg::LevelLow;
    else                      tank_level = fdpi_pkg::LevelMid;
  end

  assign result = {tank_level, levels.gallon, levels.high, levels.mid,
                   pump.fresh, pump.overrun, pump.drive};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      primed_q     <= 1'b0;
      float_win_q  <= fdpi_pkg::FloatWinRst;
      gallon_win_q <= fdpi_pkg::GallonWinRst;
      max_run_q    <= fdpi_pkg::MaxRunRst;
      min_rest_q   <= fdpi_pkg::MinRestRst;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        primed_q <= 1'b1;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          fdpi_pkg::RegFloatWin:  float_win_q  <= cfg_data_i[fdpi_pkg::WinW-1:0];
          fdpi_pkg::RegGallonWin: gallon_win_q <= cfg_data_i[fdpi_pkg::WinW-1:0];
          fdpi_pkg::RegMaxRun:    max_run_q    <= cfg_data_i[fdpi_pkg::TimerW-1:0];
          fdpi_pkg::RegMinRest:   min_rest_q   <= cfg_data_i[fdpi_pkg::TimerW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pins_q <= s_axis_tdata[2:0];
    end
    if (adv) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `FDPI_ASSERT(a_dry_interlock, out_valid_q |-> !(out_data_q[0] && out_data_q[5]))
  `FDPI_ASSERT_NEXT(a_adv_fills, adv, out_valid_q)

endmodule
